// ----- rtl/rtcaq_pkg.sv -----
`default_nettype none

package rtcaq_pkg;

    // Queue depth default and per-tick fire limit
    localparam int ALARM_SLOTS_DEF = 8;
    localparam int FIRE_LIMIT      = 8;

    // Input actions
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_ADD    = 2'd2;
    localparam logic [1:0] ACT_CANCEL = 2'd3;

    // Result kinds
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_QUEUED = 2'd1;
    localparam logic [1:0] ST_INVALID    = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/rtc_alarm_queue.sv -----
// Channel   | Handshake              | Payload
// ----------+------------------------+--------------------------------------------------
// input     | in_valid / in_ready    | action, alarm_handle, time_value
// result    | out_valid / out_ready  | result_kind, fired_handle, current_time, status,
//           |                        | last_result
// config    | cfg_we (no wait)       | cfg_wdata = counter_run
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Set time and a stopped or invalid tick go straight to the final result; a running tick
// first emits one fired result per due alarm, up to the fire limit. Cancel and add walk the
// queue one entry per cycle through the single shared comparator; add walks it to find, then to insert.
// Output stalls hold the sequencer in place; one result may wait in the output
// register while the next item is taken. Reset: time invalid, queue empty.
`default_nettype none

module rtc_alarm_queue #(
    parameter int ALARM_SLOTS = rtcaq_pkg::ALARM_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [2:0]  alarm_handle,
    input  wire logic [31:0] time_value,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [2:0]       fired_handle,
    output logic [31:0]      current_time,
    output logic [1:0]       status,
    output logic             last_result
);

    localparam int IDX_W  = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int FILL_W = $clog2(ALARM_SLOTS + 1);
    localparam int FIRE_W = $clog2(rtcaq_pkg::FIRE_LIMIT + 1);

    localparam logic [FILL_W-1:0] SLOTS_N = FILL_W'(ALARM_SLOTS);
    localparam logic [FIRE_W-1:0] FIRE_N  = FIRE_W'(rtcaq_pkg::FIRE_LIMIT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_FIRE = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FIRE_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic              run_reg;
    logic              valid_reg, valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       count_reg, count_next;

    // current item
    logic [1:0]        act_reg, act_next;
    logic [2:0]        hdl_reg, hdl_next;
    logic [31:0]       tval_reg, tval_next;
    logic [1:0]        status_reg, status_next;

    // queue storage
    logic [31:0]       q_time_reg [ALARM_SLOTS];
    logic [31:0]       q_time_next [ALARM_SLOTS];
    logic [2:0]        q_hdl_reg [ALARM_SLOTS];
    logic [2:0]        q_hdl_next [ALARM_SLOTS];

    // output payload
    logic              kind_reg;
    logic [2:0]        ohdl_reg;
    logic [31:0]       otime_reg;
    logic [1:0]        ostat_reg;
    logic              olast_reg;

    logic              emit;
    logic              emit_kind;
    logic [2:0]        emit_hdl;
    logic [1:0]        emit_status;
    logic              emit_last;
    logic              shift_rm;
    logic              shift_ins;
    logic              slot_free;

    logic [31:0]       rd_time;
    logic [2:0]        rd_hdl;
    logic [31:0]       cmp_a, cmp_b;
    logic              cmp_eq, cmp_gt;

    assign in_ready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // queue read port at the walk index
    assign rd_time = q_time_reg[idx_reg[IDX_W-1:0]];
    assign rd_hdl  = q_hdl_reg[idx_reg[IDX_W-1:0]];

    // shared comparator
    always_comb
    begin
        if (state_reg == S_FIND)
        begin
            cmp_a = {29'd0, rd_hdl};
            cmp_b = {29'd0, hdl_reg};
        end
        else if (state_reg == S_INS)
        begin
            cmp_a = tval_reg;
            cmp_b = rd_time;
        end
        else
        begin
            cmp_a = rd_time;
            cmp_b = count_reg;
        end
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_gt = (cmp_a > cmp_b);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        fire_cnt_next = fire_cnt_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        act_next      = act_reg;
        hdl_next      = hdl_reg;
        tval_next     = tval_reg;
        status_next   = status_reg;
        shift_rm      = 1'b0;
        shift_ins     = 1'b0;
        emit          = 1'b0;
        emit_kind     = rtcaq_pkg::KIND_ACK;
        emit_hdl      = hdl_reg;
        emit_status   = status_reg;
        emit_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next      = action;
                    hdl_next      = alarm_handle;
                    tval_next     = time_value;
                    idx_next      = '0;
                    fire_cnt_next = '0;
                    status_next   = rtcaq_pkg::ST_OK;
                    unique case (action)
                        rtcaq_pkg::ACT_TICK:
                        begin
                            hdl_next = 3'd0;
                            if (!valid_reg)
                            begin
                                status_next = rtcaq_pkg::ST_INVALID;
                                state_next  = S_EMIT;
                            end
                            else if (run_reg)
                            begin
                                count_next = count_reg + 32'd1;
                                state_next = S_FIRE;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        rtcaq_pkg::ACT_SET:
                        begin
                            count_next = time_value;
                            valid_next = 1'b1;
                            state_next = S_EMIT;
                        end
                        rtcaq_pkg::ACT_ADD:
                        begin
                            state_next = S_FIND;
                        end
                        rtcaq_pkg::ACT_CANCEL:
                        begin
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // look for the handle, drop it if queued
            S_FIND:
            begin
                if (idx_reg >= fill_reg)
                begin
                    if (act_reg == rtcaq_pkg::ACT_ADD)
                    begin
                        idx_next   = '0;
                        state_next = S_INS;
                    end
                    else
                    begin
                        status_next = rtcaq_pkg::ST_NOT_QUEUED;
                        state_next  = S_EMIT;
                    end
                end
                else if (cmp_eq)
                begin
                    shift_rm  = 1'b1;
                    fill_next = fill_reg - FILL_W'(1);
                    if (act_reg == rtcaq_pkg::ACT_ADD)
                    begin
                        idx_next   = '0;
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + FILL_W'(1);
                end
            end

            // walk past earlier due times, then insert; a full queue drops its latest entry or the new one
            S_INS:
            begin
                if ((idx_reg < fill_reg) && cmp_gt)
                begin
                    idx_next = idx_reg + FILL_W'(1);
                end
                else
                begin
                    if (idx_reg < SLOTS_N)
                    begin
                        shift_ins = 1'b1;
                        if (fill_reg != SLOTS_N)
                        begin
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                    state_next = S_EMIT;
                end
            end

            // pop due alarms from the head
            S_FIRE:
            begin
                if ((fill_reg == '0) || (fire_cnt_reg == FIRE_N) || cmp_gt)
                begin
                    state_next = S_EMIT;
                end
                else if (slot_free)
                begin
                    emit          = 1'b1;
                    emit_kind     = rtcaq_pkg::KIND_FIRED;
                    emit_hdl      = rd_hdl;
                    emit_status   = rtcaq_pkg::ST_OK;
                    emit_last     = 1'b0;
                    shift_rm      = 1'b1;
                    fill_next     = fill_reg - FILL_W'(1);
                    fire_cnt_next = fire_cnt_reg + FIRE_W'(1);
                end
            end

            // final result of the item
            S_EMIT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // queue shifting: remove at idx or open a slot at idx
    always_comb
    begin
        for (int j = 0; j < ALARM_SLOTS; j++)
        begin
            q_time_next[j] = q_time_reg[j];
            q_hdl_next[j]  = q_hdl_reg[j];
            if (shift_rm && (FILL_W'(j) >= idx_reg) && (j < ALARM_SLOTS - 1))
            begin
                q_time_next[j] = q_time_reg[IDX_W'(j + 1)];
                q_hdl_next[j]  = q_hdl_reg[IDX_W'(j + 1)];
            end
            if (shift_ins)
            begin
                if (FILL_W'(j) > idx_reg)
                begin
                    q_time_next[j] = q_time_reg[IDX_W'(j - 1)];
                    q_hdl_next[j]  = q_hdl_reg[IDX_W'(j - 1)];
                end
                else if (FILL_W'(j) == idx_reg)
                begin
                    q_time_next[j] = tval_reg;
                    q_hdl_next[j]  = hdl_reg;
                end
            end
        end
    end

    // output valid
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            fill_reg      <= '0;
            fire_cnt_reg  <= '0;
            run_reg       <= 1'b0;
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            fire_cnt_reg  <= fire_cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cfg_we)
            begin
                run_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        hdl_reg    <= hdl_next;
        tval_reg   <= tval_next;
        status_reg <= status_next;
        for (int j = 0; j < ALARM_SLOTS; j++)
        begin
            q_time_reg[j] <= q_time_next[j];
            q_hdl_reg[j]  <= q_hdl_next[j];
        end
        if (emit)
        begin
            kind_reg  <= emit_kind;
            ohdl_reg  <= emit_hdl;
            otime_reg <= count_reg;
            ostat_reg <= emit_status;
            olast_reg <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign fired_handle = ohdl_reg;
    assign current_time = otime_reg;
    assign status       = ostat_reg;
    assign last_result  = olast_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOTS_N)
        else $error("queue fill above depth");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_N)
        else $error("fire count above limit");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND || state_reg == S_INS) |-> idx_reg <= fill_reg)
        else $error("walk index beyond fill");

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == rtcaq_pkg::ACT_TICK && valid_reg && run_reg)
        |=> count_reg == $past(count_reg) + 32'd1)
        else $error("tick did not advance count");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == rtcaq_pkg::KIND_FIRED) |-> !olast_reg)
        else $error("fired alarm marked last");
`endif

endmodule

`default_nettype wire
